FILE: sv/mhse_pkg.sv
// ----------------------------------------------------------------------------
// mhse_pkg
// shared types and constants for the modular horner share evaluator
// ----------------------------------------------------------------------------
package mhse_pkg;

    localparam int SCALAR_LIMBS = 4;
    localparam int LIMB_W       = 64;
    localparam int SCALAR_W     = SCALAR_LIMBS * LIMB_W;
    localparam int WIDE_W       = SCALAR_W + 1;
    localparam int BIT_CNT_W    = $clog2(SCALAR_W);
    localparam int CFG_IDX_W    = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_LIMB0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_LIMB1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_LIMB2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_LIMB3 = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_ACC,
        ST_RED_COEF,
        ST_MUL_SHIFT,
        ST_MUL_ADD,
        ST_FINAL,
        ST_OUT
    } t_state;

endpackage

FILE: sv/modular_horner_share_eval_unit.sv
// ----------------------------------------------------------------------------
// modular_horner_share_eval_unit
// horner-rule polynomial evaluation modulo a programmed 256-bit group order
// steps per item after accept: serial reduce of acc, reduce of coef, then
// interleaved multiply by the point, a shift step per bit plus an add step per
// set bit, with the coefficient added in a last fold step; no new item is taken
// until the current one is done, as every step uses the single shared
// shift/add/conditional-subtract unit, which works on one bit at a time
// reset: synchronous active low, clears modulus, accumulator and control
// ----------------------------------------------------------------------------
module modular_horner_share_eval_unit
    import mhse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMB_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [LIMB_W-1:0]    i_coef_limb0,
    input  logic [LIMB_W-1:0]    i_coef_limb1,
    input  logic [LIMB_W-1:0]    i_coef_limb2,
    input  logic [LIMB_W-1:0]    i_coef_limb3,
    input  logic [LIMB_W-1:0]    i_point_limb0,
    input  logic [LIMB_W-1:0]    i_point_limb1,
    input  logic [LIMB_W-1:0]    i_point_limb2,
    input  logic [LIMB_W-1:0]    i_point_limb3,
    input  logic                 i_last_coef,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [LIMB_W-1:0]    o_share_limb0,
    output logic [LIMB_W-1:0]    o_share_limb1,
    output logic [LIMB_W-1:0]    o_share_limb2,
    output logic [LIMB_W-1:0]    o_share_limb3
);

    // modulus and accumulator
    logic [SCALAR_W-1:0]  r_mod;
    logic [SCALAR_W-1:0]  r_acc, n_acc;
    // latched operands of the current item
    logic [SCALAR_W-1:0]  r_coef, n_coef;
    logic [SCALAR_W-1:0]  r_point, n_point;
    logic                 r_last, n_last;
    // reduced accumulator and coefficient, and running value of the shared unit
    logic [SCALAR_W-1:0]  r_acc_red, n_acc_red;
    logic [SCALAR_W-1:0]  r_coef_red, n_coef_red;
    logic [WIDE_W-1:0]    r_work, n_work;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    t_state               r_state, n_state;
    logic [SCALAR_W-1:0]  r_share, n_share;

    logic                 qzero;
    logic                 in_acc;

    // shared unit: operand select, optional add, then one fold
    logic [WIDE_W-1:0]    unit_in;
    logic [WIDE_W-1:0]    unit_out;

    assign qzero  = (r_mod == '0);
    assign in_acc = i_valid && !o_stall;

    always_comb begin
        logic [WIDE_W-1:0] diff;
        diff = unit_in - {1'b0, r_mod};
        if (qzero) begin
            unit_out = {1'b0, unit_in[SCALAR_W-1:0]};
        end else if (unit_in >= {1'b0, r_mod}) begin
            unit_out = diff;
        end else begin
            unit_out = unit_in;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_RED_ACC:   unit_in = {r_work[SCALAR_W-1:0], r_acc[r_bit]};
            ST_RED_COEF:  unit_in = {r_work[SCALAR_W-1:0], r_coef[r_bit]};
            ST_MUL_SHIFT: unit_in = {r_work[SCALAR_W-1:0], 1'b0};
            ST_MUL_ADD:   unit_in = r_work + {1'b0, r_acc_red};
            ST_FINAL:     unit_in = r_work + {1'b0, r_coef_red};
            default:      unit_in = r_work;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= '0;
            r_acc   <= '0;
            r_state <= ST_IDLE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODULUS_LIMB0: r_mod[0*LIMB_W +: LIMB_W] <= i_cfg_data;
                    CFG_MODULUS_LIMB1: r_mod[1*LIMB_W +: LIMB_W] <= i_cfg_data;
                    CFG_MODULUS_LIMB2: r_mod[2*LIMB_W +: LIMB_W] <= i_cfg_data;
                    CFG_MODULUS_LIMB3: r_mod[3*LIMB_W +: LIMB_W] <= i_cfg_data;
                    default: ;
                endcase
            end
            r_acc   <= n_acc;
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef     <= n_coef;
        r_point    <= n_point;
        r_last     <= n_last;
        r_acc_red  <= n_acc_red;
        r_coef_red <= n_coef_red;
        r_work     <= n_work;
        r_bit      <= n_bit;
        r_share    <= n_share;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_coef     = r_coef;
        n_point    = r_point;
        n_last     = r_last;
        n_acc_red  = r_acc_red;
        n_coef_red = r_coef_red;
        n_work     = r_work;
        n_bit      = r_bit;
        n_share    = r_share;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_coef  = {i_coef_limb3, i_coef_limb2, i_coef_limb1, i_coef_limb0};
                    n_point = {i_point_limb3, i_point_limb2, i_point_limb1,
                               i_point_limb0};
                    n_last  = i_last_coef;
                    n_work  = '0;
                    n_bit   = BIT_CNT_W'(SCALAR_W - 1);
                    n_state = ST_RED_ACC;
                end
            end
            ST_RED_ACC: begin
                n_work = unit_out;
                n_bit  = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_acc_red = unit_out[SCALAR_W-1:0];
                    n_work    = '0;
                    n_bit     = BIT_CNT_W'(SCALAR_W - 1);
                    n_state   = ST_RED_COEF;
                end
            end
            ST_RED_COEF: begin
                n_work = unit_out;
                n_bit  = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_coef_red = unit_out[SCALAR_W-1:0];
                    n_work     = '0;
                    n_bit      = BIT_CNT_W'(SCALAR_W - 1);
                    n_state    = ST_MUL_SHIFT;
                end
            end
            ST_MUL_SHIFT: begin
                n_work = unit_out;
                if (r_point[r_bit]) begin
                    n_state = ST_MUL_ADD;
                end else if (r_bit == '0) begin
                    n_state = ST_FINAL;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_MUL_ADD: begin
                n_work = unit_out;
                if (r_bit == '0) begin
                    n_state = ST_FINAL;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = ST_MUL_SHIFT;
                end
            end
            ST_FINAL: begin
                if (r_last) begin
                    n_acc   = '0;
                    n_share = unit_out[SCALAR_W-1:0];
                    n_state = ST_OUT;
                end else begin
                    n_acc   = unit_out[SCALAR_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_share_limb0 = r_share[0*LIMB_W +: LIMB_W];
    assign o_share_limb1 = r_share[1*LIMB_W +: LIMB_W];
    assign o_share_limb2 = r_share[2*LIMB_W +: LIMB_W];
    assign o_share_limb3 = r_share[3*LIMB_W +: LIMB_W];

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the modular horner share evaluator: a table of
// directed items, then random polynomials under several moduli, every share
// compared limb by limb against a hand-typed value or an exact big-integer horner predictor
// ----------------------------------------------------------------------------
module tb_top
    import mhse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYC  = 1100;    // one full item of the serial datapath
    localparam int HOLD_CYC    = 3000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 175;

    typedef logic [SCALAR_W-1:0] t_scalar;

    // one row of the directed table: either a modulus write or an item
    typedef struct {
        bit      is_cfg;
        t_scalar val;        // modulus for a cfg row, coefficient otherwise
        t_scalar pt;
        bit      last;
        bit      has_share;  // share typed in by hand
        t_scalar share;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIMB_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [LIMB_W-1:0]    i_coef_limb0, i_coef_limb1, i_coef_limb2, i_coef_limb3;
    logic [LIMB_W-1:0]    i_point_limb0, i_point_limb1, i_point_limb2, i_point_limb3;
    logic                 i_last_coef;
    logic                 o_valid;
    logic                 i_stall;
    logic [LIMB_W-1:0]    o_share_limb0, o_share_limb1, o_share_limb2, o_share_limb3;

    modular_horner_share_eval_unit uut (.*);

    // predictor state: programmed group order and running accumulator
    t_scalar group_order;
    t_scalar horner_acc;
    t_scalar share_q[$];

    int  mismatches;
    int  items_sent;
    int  shares_seen;
    bit  calm;       // no idling on either side
    bit  hold_req;   // receiver holds off for a long stretch
    t_row rows[$];

    always #5 i_clk = ~i_clk;

    // exact (acc*x + c) mod q; a zero modulus wraps at 2^256
    function automatic t_scalar horner_step(t_scalar acc, t_scalar c, t_scalar x,
                                            t_scalar q);
        logic [2*SCALAR_W:0] wide;
        wide = {{(SCALAR_W+1){1'b0}}, acc};
        wide = wide * {{(SCALAR_W+1){1'b0}}, x};
        wide = wide + {{(SCALAR_W+1){1'b0}}, c};
        if (q == '0)
            return wide[SCALAR_W-1:0];
        wide = wide % {{(SCALAR_W+1){1'b0}}, q};
        return wide[SCALAR_W-1:0];
    endfunction

    function automatic t_scalar rand_scalar();
        t_scalar v;
        for (int i = 0; i < SCALAR_LIMBS; i++)
            v[i*LIMB_W +: LIMB_W] = {$urandom, $urandom};
        return v;
    endfunction

    // coefficient mix: below q, at q, extremes and unreduced
    function automatic t_scalar rand_coef();
        t_scalar v;
        v = rand_scalar();
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            2: v = group_order;
            3: v = group_order - 1;
            4, 5: v = v;
            default: if (group_order != '0) v = v % group_order;
        endcase
        return v;
    endfunction

    // mostly 64-bit points, sometimes small participant ids, all ones or full width
    function automatic t_scalar rand_point();
        t_scalar v;
        v = '0;
        case ($urandom_range(5))
            0: v = rand_scalar();
            1: v = '1;
            2: v[LIMB_W-1:0] = LIMB_W'($urandom_range(1, 16));
            default: v[LIMB_W-1:0] = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic add_row(bit is_cfg, t_scalar val, t_scalar pt, bit last,
                           bit has_share, t_scalar share);
        t_row r;
        r.is_cfg = is_cfg; r.val = val; r.pt = pt; r.last = last;
        r.has_share = has_share; r.share = share;
        rows.push_back(r);
    endtask

    // wait until all shares are out and any item without a share has drained
    task automatic wait_idle();
        wait (share_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_modulus(t_scalar q, bit poke_unused);
        for (int i = int'(CFG_MODULUS_LIMB0); i <= int'(CFG_MODULUS_LIMB3); i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= q[i*LIMB_W +: LIMB_W];
        end
        // index past the last limb must be ignored
        if (poke_unused) begin
            @(negedge i_clk);
            i_cfg_idx  <= CFG_IDX_W'($urandom_range(int'(CFG_MODULUS_LIMB3) + 1,
                                                    (1 << CFG_IDX_W) - 1));
            i_cfg_data <= {$urandom, $urandom};
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        group_order = q;
    endtask

    // offer one item, hold it until accepted, then update the predictor
    task automatic send_item(t_scalar c, t_scalar x, bit last, bit has_share,
                             t_scalar share);
        t_scalar nxt;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_coef_limb0  <= c[0 +: LIMB_W];
        i_coef_limb1  <= c[LIMB_W +: LIMB_W];
        i_coef_limb2  <= c[2*LIMB_W +: LIMB_W];
        i_coef_limb3  <= c[3*LIMB_W +: LIMB_W];
        i_point_limb0 <= x[0 +: LIMB_W];
        i_point_limb1 <= x[LIMB_W +: LIMB_W];
        i_point_limb2 <= x[2*LIMB_W +: LIMB_W];
        i_point_limb3 <= x[3*LIMB_W +: LIMB_W];
        i_last_coef   <= last;
        do @(posedge i_clk); while (o_stall);
        nxt = horner_step(horner_acc, c, x, group_order);
        if (last) begin
            share_q.push_back(has_share ? share : nxt);
            horner_acc = '0;
        end else begin
            horner_acc = nxt;
        end
        items_sent++;
        // drop valid at the next falling edge
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // receiver: random stall, a calm window, and one long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            i_stall <= 1'b1;
            repeat (HOLD_CYC) @(negedge i_clk);
            hold_req = 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 23);
        end
    end

    // share checker
    always @(posedge i_clk) begin
        t_scalar got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_share_limb3, o_share_limb2, o_share_limb1, o_share_limb0};
            shares_seen++;
            if (share_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected share %h", got);
            end else begin
                want = share_q.pop_front();
                for (int i = 0; i < SCALAR_LIMBS; i++)
                    if (got[i*LIMB_W +: LIMB_W] !== want[i*LIMB_W +: LIMB_W]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("share_limb%0d: expected %h, got %h", i,
                                     want[i*LIMB_W +: LIMB_W], got[i*LIMB_W +: LIMB_W]);
                    end
            end
        end
    end

    // watchdog
    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_scalar one, two, three, five, ten, q_big;
        int      deg;
        i_clk = 1'b0; i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_stall = 1'b0; i_last_coef = 1'b0;
        {i_coef_limb0, i_coef_limb1, i_coef_limb2, i_coef_limb3} = '0;
        {i_point_limb0, i_point_limb1, i_point_limb2, i_point_limb3} = '0;
        group_order = '0; horner_acc = '0;
        mismatches = 0; items_sent = 0; shares_seen = 0;
        calm = 1'b0; hold_req = 1'b0;
        one = 1; two = 2; three = 3; five = 5; ten = 10;
        q_big = {1'b1, {(SCALAR_W-2){1'b0}}, 1'b1};

        // modulus zero after reset: plain wrap at 2^256
        add_row(0, '1, '1, 1, 1, '1);          // lone last coefficient
        add_row(0, five, '1, 0, 0, '0);
        add_row(0, '0, two, 1, 1, ten);        // 5*2
        add_row(0, '1, '0, 0, 0, '0);
        add_row(0, three, two, 1, 1, one);     // (2^256-1)*2+3 wraps to 1
        // largest modulus
        add_row(1, '1, '0, 0, 0, '0);
        add_row(0, '1, '1, 1, 1, '0);          // c equal to q reduces to zero
        add_row(0, '1, '0, 0, 0, '0);
        add_row(0, five, '1, 1, 1, five);      // point equal to q
        add_row(0, '1 - 1, three, 0, 0, '0);
        add_row(0, '1, '1, 0, 0, '0);
        add_row(0, one, q_big, 1, 0, '0);
        // modulus one: every share is zero
        add_row(1, one, '0, 0, 0, '0);
        add_row(0, '1, '1, 0, 0, '0);
        add_row(0, ten, five, 1, 1, '0);
        // large odd modulus, mostly unreduced operands
        add_row(1, q_big, '0, 0, 0, '0);
        add_row(0, '1, '1, 0, 0, '0);
        add_row(0, q_big, q_big + 7, 0, 0, '0);
        add_row(0, '1, '1, 1, 0, '0);
        add_row(0, '0, three, 0, 0, '0);
        // accumulator left open across a modulus change
        add_row(1, ten, '0, 0, 0, '0);
        add_row(0, '1, five, 1, 0, '0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_idle();
                write_modulus(rows[i].val, 1'b1);
            end else begin
                send_item(rows[i].val, rows[i].pt, rows[i].last,
                          rows[i].has_share, rows[i].share);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            t_scalar q;
            int      start;
            wait_idle();
            q = rand_scalar();
            case (ph)
                1: q[SCALAR_W-1] = 1'b1;
                2: q = {{(SCALAR_W-LIMB_W){1'b0}}, q[LIMB_W-1:0] | 64'h1};
                3: q = '1;
                default: q = q;
            endcase
            if (q == '0) q = one;
            write_modulus(q, 1'($urandom_range(1)));
            calm     = (ph == 3);
            hold_req = (ph == 2);
            start    = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                deg = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
                begin
                    t_scalar x;
                    x = rand_point();
                    for (int k = deg; k >= 0; k--)
                        send_item(rand_coef(), x, k == 0, 1'b0, '0);
                end
            end
            // sometimes leave a polynomial open into the next modulus
            if ($urandom_range(1))
                send_item(rand_coef(), rand_point(), 1'b0, 1'b0, '0);
            calm = 1'b0;
        end
        // close any open polynomial
        send_item(rand_coef(), rand_point(), 1'b1, 1'b0, '0);

        wait (share_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("run covered %0d coefficient items and %0d shares over %0d moduli",
                 items_sent, shares_seen, RAND_PHASES + 5);
        $display("including zero, one and all-ones moduli, a long output hold-off");
        if (mismatches == 0 && share_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
